@@ rtl/clipped_line_pixel_generator_unit_assert.svh @@
// Assertion macros for the clipped line pixel generator.
`ifndef CLIPPED_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH
`define CLIPPED_LINE_PIXEL_GENERATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define CLPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("clpg assertion failed");

// Next-cycle implication, disabled while in reset.
`define CLPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("clpg assertion failed");

`endif

@@ rtl/clpg_pkg.sv @@
// Shared types and constants of the clipped line pixel generator.
`default_nettype none

package clpg_pkg;

    localparam int COORD_BITS = 16;
    localparam int ADDR_BITS  = 32;
    localparam int COLOR_BITS = 32;
    localparam int PITCH_BITS = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    // Request opcodes
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Raster modes
    localparam logic [1:0] MODE_COPY   = 2'd0;
    localparam logic [1:0] MODE_OR     = 2'd1;
    localparam logic [1:0] MODE_AND    = 2'd2;
    localparam logic [1:0] MODE_INVERT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_TOP    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_RIGHT  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_ROW_WORDS   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_BASE  = 3'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FG_COLOR    = 3'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BG_COLOR    = 3'd7;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // One bit wider so stepping past the end of the range does not wrap
    typedef logic signed [COORD_BITS:0]   cur_t;
    typedef logic        [COORD_BITS:0]   delta_t;
    typedef logic        [COORD_BITS+1:0] err_t;
    typedef logic        [COORD_BITS:0]   steps_t;
    typedef logic        [ADDR_BITS-1:0]  addr_t;
    typedef logic        [COLOR_BITS-1:0] color_t;

    typedef struct packed {
        logic       op;
        coord_t     x_start;
        coord_t     y_start;
        coord_t     x_end;
        coord_t     y_end;
        logic [1:0] raster_mode;
    } req_t;

    typedef struct packed {
        logic   write_valid;
        addr_t  word_address;
        color_t pixel_word;
        logic   invert;
        logic   line_done;
        logic   idle;
    } rsp_t;

    typedef struct packed {
        coord_t                clip_left;
        coord_t                clip_top;
        coord_t                clip_right;
        coord_t                clip_bottom;
        logic [PITCH_BITS-1:0] row_words;
        addr_t                 frame_base;
        color_t                fg_color;
        color_t                bg_color;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/clpg_cfg.sv @@
// Configuration register file of the clipped line pixel generator.
`default_nettype none

module clpg_cfg
    import clpg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data,
    output cfg_t                          cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CLIP_LEFT:   cfg_next.clip_left   = coord_t'(cfg_data[COORD_BITS-1:0]);
                CFG_CLIP_TOP:    cfg_next.clip_top    = coord_t'(cfg_data[COORD_BITS-1:0]);
                CFG_CLIP_RIGHT:  cfg_next.clip_right  = coord_t'(cfg_data[COORD_BITS-1:0]);
                CFG_CLIP_BOTTOM: cfg_next.clip_bottom = coord_t'(cfg_data[COORD_BITS-1:0]);
                CFG_ROW_WORDS:   cfg_next.row_words   = cfg_data[PITCH_BITS-1:0];
                CFG_FRAME_BASE:  cfg_next.frame_base  = cfg_data[ADDR_BITS-1:0];
                CFG_FG_COLOR:    cfg_next.fg_color    = cfg_data[COLOR_BITS-1:0];
                CFG_BG_COLOR:    cfg_next.bg_color    = cfg_data[COLOR_BITS-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/clpg_core.sv @@
// Line state registers and combinational Bresenham step/clip datapath.
`default_nettype none

module clpg_core
    import clpg_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cfg_t      cfg,
    input  wire logic step_en,
    input  req_t      req,
    output rsp_t      rsp
);

    cur_t       cur_x_reg,       cur_x_next;
    cur_t       cur_y_reg,       cur_y_next;
    addr_t      cur_address_reg, cur_address_next;
    err_t       err_acc_reg,     err_acc_next;
    steps_t     steps_left_reg,  steps_left_next;
    delta_t     delta_x_reg,     delta_x_next;
    delta_t     delta_y_reg,     delta_y_next;
    logic       y_down_reg,      y_down_next;
    logic       x_major_reg,     x_major_next;
    logic       line_active_reg, line_active_next;
    logic [1:0] mode_held_reg,   mode_held_next;

    // Start request decode
    cur_t                          x1, y1, x2, y2, dxs, dys;
    delta_t                        dx, dy, major;
    logic                          dy_neg, xmaj;
    logic signed [COORD_BITS+PITCH_BITS:0] prod;
    addr_t                         start_addr;

    // Step datapath
    cur_t   cl, cr, ct, cb, x_plus;
    logic   in_clip, exit_right, col, row, done;
    err_t   esum, err_step;
    addr_t  row_off, step_addr;
    color_t color;

    always_comb
    begin
        x1  = {req.x_start[COORD_BITS-1], req.x_start};
        y1  = {req.y_start[COORD_BITS-1], req.y_start};
        x2  = {req.x_end[COORD_BITS-1],   req.x_end};
        y2  = {req.y_end[COORD_BITS-1],   req.y_end};
        dxs = x2 - x1;
        dys = y2 - y1;
        dx  = dxs[COORD_BITS] ? '0 : delta_t'(dxs);
        dy_neg = dys[COORD_BITS];
        dy  = dy_neg ? delta_t'(-dys) : delta_t'(dys);
        xmaj  = dx > dy;
        major = xmaj ? dx : dy;
        // row offset, signed y times unsigned pitch, wraps into 32 bits
        prod  = $signed(req.y_start) * $signed({1'b0, cfg.row_words});
        start_addr = cfg.frame_base + addr_t'(prod[ADDR_BITS-1:0])
                   + {{(ADDR_BITS-COORD_BITS){req.x_start[COORD_BITS-1]}}, req.x_start};
    end

    always_comb
    begin
        cl = {cfg.clip_left[COORD_BITS-1],   cfg.clip_left};
        cr = {cfg.clip_right[COORD_BITS-1],  cfg.clip_right};
        ct = {cfg.clip_top[COORD_BITS-1],    cfg.clip_top};
        cb = {cfg.clip_bottom[COORD_BITS-1], cfg.clip_bottom};
        in_clip = (cur_x_reg >= cl) && (cur_x_reg <= cr)
               && (cur_y_reg >= ct) && (cur_y_reg <= cb);
        x_plus = cur_x_reg + cur_t'(1);

        col        = 1'b0;
        row        = 1'b0;
        exit_right = 1'b0;
        esum       = '0;
        err_step   = err_acc_reg;
        if (x_major_reg)
        begin
            if (!in_clip && (cur_x_reg > cr))
            begin
                exit_right = 1'b1;
            end
            else
            begin
                col  = 1'b1;
                esum = err_acc_reg + err_t'(delta_y_reg);
                if (esum >= err_t'(delta_x_reg))
                begin
                    row      = 1'b1;
                    err_step = esum - err_t'(delta_x_reg);
                end
                else
                begin
                    err_step = esum;
                end
            end
        end
        else
        begin
            row  = 1'b1;
            esum = err_acc_reg + err_t'(delta_x_reg);
            if (esum >= err_t'(delta_y_reg))
            begin
                col        = 1'b1;
                err_step   = esum - err_t'(delta_y_reg);
                exit_right = x_plus > cr;
            end
            else
            begin
                err_step = esum;
            end
        end

        // last pixel: right clip exit, or counter about to reach zero
        done = exit_right || (steps_left_reg == steps_t'(1));

        row_off   = row ? addr_t'(cfg.row_words) : '0;
        step_addr = y_down_reg ? (cur_address_reg - row_off) : (cur_address_reg + row_off);
        step_addr = step_addr + addr_t'(col);

        unique case (mode_held_reg)
            MODE_INVERT: color = '1;
            MODE_AND:    color = cfg.bg_color;
            MODE_COPY,
            MODE_OR:     color = cfg.fg_color;
            default:     color = cfg.fg_color;
        endcase
    end

    // Result of a step request
    always_comb
    begin
        rsp = '0;
        if (!line_active_reg)
        begin
            rsp.idle = 1'b1;
        end
        else
        begin
            rsp.line_done = done;
            if (in_clip)
            begin
                rsp.write_valid  = 1'b1;
                rsp.word_address = cur_address_reg;
                rsp.pixel_word   = color;
                rsp.invert       = (mode_held_reg == MODE_INVERT);
            end
        end
    end

    always_comb
    begin
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        cur_address_next = cur_address_reg;
        err_acc_next     = err_acc_reg;
        steps_left_next  = steps_left_reg;
        delta_x_next     = delta_x_reg;
        delta_y_next     = delta_y_reg;
        y_down_next      = y_down_reg;
        x_major_next     = x_major_reg;
        line_active_next = line_active_reg;
        mode_held_next   = mode_held_reg;
        if (step_en)
        begin
            if (req.op == OP_START)
            begin
                cur_x_next       = x1;
                cur_y_next       = y1;
                cur_address_next = start_addr;
                err_acc_next     = err_t'(major >> 1);
                steps_left_next  = major + steps_t'(1);
                delta_x_next     = dx;
                delta_y_next     = dy;
                y_down_next      = dy_neg;
                x_major_next     = xmaj;
                line_active_next = 1'b1;
                mode_held_next   = req.raster_mode;
            end
            else if (line_active_reg)
            begin
                line_active_next = !done;
                if (!exit_right)
                begin
                    cur_x_next       = col ? x_plus : cur_x_reg;
                    cur_y_next       = !row ? cur_y_reg
                                     : (y_down_reg ? cur_y_reg - cur_t'(1)
                                                   : cur_y_reg + cur_t'(1));
                    cur_address_next = step_addr;
                    err_acc_next     = err_step;
                    steps_left_next  = steps_left_reg - steps_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            cur_address_reg <= '0;
            err_acc_reg     <= '0;
            steps_left_reg  <= '0;
            delta_x_reg     <= '0;
            delta_y_reg     <= '0;
            y_down_reg      <= 1'b0;
            x_major_reg     <= 1'b0;
            line_active_reg <= 1'b0;
            mode_held_reg   <= MODE_COPY;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            cur_address_reg <= cur_address_next;
            err_acc_reg     <= err_acc_next;
            steps_left_reg  <= steps_left_next;
            delta_x_reg     <= delta_x_next;
            delta_y_reg     <= delta_y_next;
            y_down_reg      <= y_down_next;
            x_major_reg     <= x_major_next;
            line_active_reg <= line_active_next;
            mode_held_reg   <= mode_held_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/clipped_line_pixel_generator_unit.sv @@
// Top level: clipped Bresenham line pixel generator with request / result registers.
// Each step is one add/compare pass over the line state into the result register.
// Throughput: one request per cycle while the result channel does not stall a step.
// A start request yields no result; it loads the line state through one 17x16 multiply.
// Reset (rst_n low, async): no line active, clip/pitch/base/colors zero, both regs empty.
`default_nettype none

`include "clipped_line_pixel_generator_unit_assert.svh"

module clipped_line_pixel_generator_unit
    import clpg_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // request channel
    input  wire logic                     req_valid,
    output logic                          req_stall,
    input  req_t                          req_data,
    // result channel
    output logic                          rsp_valid,
    input  wire logic                     rsp_stall,
    output rsp_t                          rsp_data,
    // configuration writes
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0] cfg_data
);

    // Request register: holds the accepted request until the core takes it.
    logic s1_valid_reg, s1_valid_next;
    req_t s1_req_reg,   s1_req_next;

    // Result register: parts the core from the downstream stall.
    logic rsp_valid_reg, rsp_valid_next;
    rsp_t rsp_reg,       rsp_next;

    logic req_accept;
    logic s1_fire;
    cfg_t cfg;
    rsp_t core_rsp;

    // Invert result checks
    logic rsp_inv;
    logic rsp_inv_ok;

    // Config is always taken; writes must happen only while the unit is idle, unchecked.
    assign cfg_ready = 1'b1;

    clpg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // A start needs no result slot; a step needs the result register free
    // or draining this cycle.
    assign s1_fire = s1_valid_reg
                   && ((s1_req_reg.op == OP_START) || !rsp_valid_reg || !rsp_stall);
    assign req_stall  = s1_valid_reg && !s1_fire;
    assign req_accept = req_valid && !req_stall;

    clpg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .step_en (s1_fire),
        .req     (s1_req_reg),
        .rsp     (core_rsp)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        s1_req_next   = s1_req_reg;
        if (req_accept)
        begin
            s1_valid_next = 1'b1;
            s1_req_next   = req_data;
        end
        else if (s1_fire)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (s1_fire && (s1_req_reg.op == OP_STEP))
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = core_rsp;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        s1_req_reg <= s1_req_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign rsp_inv    = rsp_valid_reg && rsp_reg.invert;
    assign rsp_inv_ok = rsp_reg.write_valid && (rsp_reg.pixel_word == '1);

    // Stall only when the request register is occupied.
    `CLPG_ASSERT_IMP(a_stall_needs_item, clk, rst_n, req_stall, s1_valid_reg)
    // A held request is neither lost nor altered while the core waits.
    `CLPG_ASSERT_NXT(a_s1_holds, clk, rst_n, req_stall, s1_valid_reg && $stable(s1_req_reg))
    // Invert results always carry a write and the all-ones mask.
    `CLPG_ASSERT_IMP(a_invert_word, clk, rst_n, rsp_inv, rsp_inv_ok)

endmodule

`default_nettype wire
